/* rtl/triangle_adjacency_finder_unit_assert.svh */
// assertion macros for the triangle adjacency finder
`ifndef TRIANGLE_ADJACENCY_FINDER_UNIT_ASSERT_SVH
`define TRIANGLE_ADJACENCY_FINDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TAF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define TAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TAF_ASSERT_SAME(label, clk, rst, ante, cons)
`define TAF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/taf_pkg.sv */
// shared types and constants of the triangle adjacency finder
package taf_pkg;

   localparam int TAF_MAX_TRIANGLES = 1024;
   localparam int TAF_INDEX_BITS    = 16;

   localparam int VERTEX_W = 16;
   localparam int NUMBER_W = 10;
   localparam logic [NUMBER_W-1:0] NUMBER_MAX = 10'd1023;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

   typedef struct packed {
      logic [1:0]          command;
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
      logic [VERTEX_W-1:0] vertex_c;
      logic [NUMBER_W-1:0] query_triangle;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [NUMBER_W-1:0] triangle_number;
      logic [NUMBER_W-1:0] neighbour_total;
      logic [NUMBER_W-1:0] neighbour_first;
      logic [NUMBER_W-1:0] neighbour_second;
      logic [NUMBER_W-1:0] neighbour_third;
      logic                more_neighbours;
      logic                edge_ab_open;
      logic                edge_bc_open;
      logic                edge_ca_open;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic take;
      logic check;
      logic scan;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic query_bad;
      logic scan_last;
   } dp_status_type;

endpackage

/* rtl/taf_ctrl.sv */
// controller state machine of the triangle adjacency finder
module taf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_command,
   input  taf_pkg::dp_status_type dp_status,
   output taf_pkg::ctl_cmd_type   ctl_cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import taf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_command == CMD_QUERY) ? ST_CHECK : ST_RESPOND;
            end
         end
         ST_CHECK: begin
            state_in = dp_status.query_bad ? ST_RESPOND : ST_SCAN;
         end
         ST_SCAN: begin
            if (dp_status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH:  state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl_cmd.take   = (state_ff == ST_IDLE) && start;
      ctl_cmd.check  = (state_ff == ST_CHECK);
      ctl_cmd.scan   = (state_ff == ST_SCAN);
      ctl_cmd.finish = (state_ff == ST_FINISH);
      busy           = (state_ff != ST_IDLE);
      rsp_strobe     = (state_ff == ST_RESPOND);
   end

endmodule

/* rtl/taf_datapath.sv */
// triangle table, scan compare and result register of the adjacency finder
module taf_datapath #(
   parameter int MAX_TRIANGLES = taf_pkg::TAF_MAX_TRIANGLES,
   parameter int INDEX_BITS    = taf_pkg::TAF_INDEX_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  taf_pkg::req_word_type  req_word,
   input  taf_pkg::ctl_cmd_type   ctl_cmd,
   output taf_pkg::dp_status_type dp_status,
   output taf_pkg::rsp_word_type  rsp_word
);
   import taf_pkg::*;

   localparam int ADDR_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);

   typedef logic [2:0][INDEX_BITS-1:0] entry_type;

   entry_type mem [MAX_TRIANGLES];

   entry_type           rd_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   entry_type           wr_data;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   q_ff, q_in;
   logic [NUMBER_W-1:0] qnum_ff, qnum_in;
   entry_type           me_ff, me_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [2:0][NUMBER_W-1:0] found_ff, found_in;
   logic [2:0]          hit_ff, hit_in;
   rsp_word_type        res_ff, res_in;

   logic [3:0]          pairs;
   logic [1:0]          hits_ab, hits_bc, hits_ca;
   logic                neighbour;
   logic                full;

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      qnum_ff  <= qnum_in;
      me_ff    <= me_in;
      idx_ff   <= idx_in;
      total_ff <= total_in;
      found_ff <= found_in;
      hit_ff   <= hit_in;
      res_ff   <= res_in;
   end

   // pair match count and edge hits of the entry under compare
   always_comb begin
      pairs   = '0;
      hits_ab = '0;
      hits_bc = '0;
      hits_ca = '0;
      for (int x = 0; x < 3; x++) begin
         for (int y = 0; y < 3; y++) begin
            if (rd_ff[x] == me_ff[y]) begin
               pairs = pairs + 4'd1;
            end
         end
         if ((rd_ff[x] == me_ff[0]) || (rd_ff[x] == me_ff[1])) hits_ab = hits_ab + 2'd1;
         if ((rd_ff[x] == me_ff[1]) || (rd_ff[x] == me_ff[2])) hits_bc = hits_bc + 2'd1;
         if ((rd_ff[x] == me_ff[2]) || (rd_ff[x] == me_ff[0])) hits_ca = hits_ca + 2'd1;
      end
      neighbour = (pairs >= 4'd2) && (idx_ff != q_ff);
   end

   assign full = 32'(count_ff) >= MAX_TRIANGLES;

   assign dp_status.query_bad = (32'(qnum_ff) >= 32'(count_ff)) ||
                                (32'(qnum_ff) >= MAX_TRIANGLES);
   assign dp_status.scan_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      count_in = count_ff;
      q_in     = q_ff;
      qnum_in  = qnum_ff;
      me_in    = me_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      res_in   = res_ff;
      rd_addr  = idx_ff + ADDR_W'(1);
      wr_en    = 1'b0;
      wr_data  = {INDEX_BITS'(req_word.vertex_c), INDEX_BITS'(req_word.vertex_b),
                  INDEX_BITS'(req_word.vertex_a)};
      priority if (ctl_cmd.take) begin
         q_in    = ADDR_W'(req_word.query_triangle);
         qnum_in = req_word.query_triangle;
         rd_addr = ADDR_W'(req_word.query_triangle);
         res_in  = '0;
         unique case (req_word.command)
            CMD_CLEAR: count_in = '0;
            CMD_LOAD: begin
               if (full) begin
                  res_in.status = STATUS_FULL;
               end else begin
                  wr_en                  = 1'b1;
                  count_in               = count_ff + CNT_W'(1);
                  res_in.triangle_number = NUMBER_W'(count_ff);
               end
            end
            default: res_in = '0;
         endcase
      end else if (ctl_cmd.check) begin
         me_in                  = rd_ff;
         idx_in                 = '0;
         total_in               = '0;
         found_in               = '0;
         hit_in                 = '0;
         rd_addr                = '0;
         res_in                 = '0;
         res_in.status          = STATUS_NOT_LOADED;
         res_in.triangle_number = qnum_ff;
      end else if (ctl_cmd.scan) begin
         idx_in = idx_ff + ADDR_W'(1);
         if (neighbour) begin
            total_in = total_ff + CNT_W'(1);
            if (32'(total_ff) < 3) begin
               found_in[total_ff[1:0]] = NUMBER_W'(idx_ff);
            end
            hit_in = hit_ff | {hits_ca >= 2'd2, hits_bc >= 2'd2, hits_ab >= 2'd2};
         end
      end else if (ctl_cmd.finish) begin
         res_in.status           = STATUS_OK;
         res_in.triangle_number  = qnum_ff;
         res_in.neighbour_total  = (32'(total_ff) > 32'(NUMBER_MAX)) ? NUMBER_MAX
                                                                    : NUMBER_W'(total_ff);
         res_in.neighbour_first  = found_ff[0];
         res_in.neighbour_second = found_ff[1];
         res_in.neighbour_third  = found_ff[2];
         res_in.more_neighbours  = 32'(total_ff) > 3;
         res_in.edge_ab_open     = !hit_ff[0];
         res_in.edge_bc_open     = !hit_ff[1];
         res_in.edge_ca_open     = !hit_ff[2];
      end else begin
         res_in = res_ff;
      end
   end

   assign rsp_word = res_ff;

endmodule

/* rtl/triangle_adjacency_finder_unit.sv */
// top level of the triangle adjacency finder
//
// channel  ports                     handshake
// req      start, busy, req_word     word taken when start is high and busy low
// rsp      rsp_strobe, rsp_word      word valid for one cycle, no back pressure
//
// clear, load and unused commands: result strobed in the cycle after the word is taken.
// query of a loaded number: result strobed after the check, scan and finish states,
// one stored entry per cycle through the single table read port.
// query of an unloaded number: result strobed after the check state, with no scan.
// reset empties the table (count to zero); table contents are not cleared.
// busy stays high from the taken word through its result strobe; results are never held off.
`include "triangle_adjacency_finder_unit_assert.svh"

module triangle_adjacency_finder_unit #(
   parameter int MAX_TRIANGLES = taf_pkg::TAF_MAX_TRIANGLES,
   parameter int INDEX_BITS    = taf_pkg::TAF_INDEX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  taf_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output taf_pkg::rsp_word_type rsp_word
);
   import taf_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   taf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_word.command),
      .dp_status   (dp_status),
      .ctl_cmd     (ctl_cmd),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe)
   );

   taf_datapath #(
      .MAX_TRIANGLES (MAX_TRIANGLES),
      .INDEX_BITS    (INDEX_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .ctl_cmd   (ctl_cmd),
      .dp_status (dp_status),
      .rsp_word  (rsp_word)
   );

   `TAF_ASSERT_NEXT(a_take_sets_busy, clock, reset, start && !busy, busy)
   `TAF_ASSERT_NEXT(a_strobe_then_idle, clock, reset, rsp_strobe, !busy && !rsp_strobe)
   `TAF_ASSERT_NEXT(a_finish_then_strobe, clock, reset, ctl_cmd.finish, rsp_strobe)
   `TAF_ASSERT_NEXT(a_bad_query_strobe, clock, reset, ctl_cmd.check && dp_status.query_bad, rsp_strobe)
   `TAF_ASSERT_SAME(a_one_command, clock, reset, busy || start, $onehot0(ctl_cmd))

endmodule

/* test/taf_neighbour_checker.sv */
// checker that predicts and compares the result words of the triangle adjacency finder
`timescale 1ns / 1ps

module taf_neighbour_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  taf_pkg::req_word_type req_word,
   input  logic                  rsp_strobe,
   input  taf_pkg::rsp_word_type rsp_word,
   output int                    fail_count,
   output int                    outstanding
);
   import taf_pkg::*;

   logic [VERTEX_W-1:0] corner_a [TAF_MAX_TRIANGLES];
   logic [VERTEX_W-1:0] corner_b [TAF_MAX_TRIANGLES];
   logic [VERTEX_W-1:0] corner_c [TAF_MAX_TRIANGLES];
   int unsigned         mesh_size;
   rsp_word_type        awaited_answers [$];

   // corners of one triangle that equal either end of an edge
   function automatic int unsigned edge_hits(input logic [VERTEX_W-1:0] t0, t1, t2, p, q);
      int unsigned n;
      n = 0;
      if (t0 == p || t0 == q) n++;
      if (t1 == p || t1 == q) n++;
      if (t2 == p || t2 == q) n++;
      return n;
   endfunction

   function automatic rsp_word_type apply_command(input req_word_type w);
      rsp_word_type        r;
      logic [VERTEX_W-1:0] mine [3];
      logic [VERTEX_W-1:0] theirs [3];
      int unsigned         total, pairs, n;
      logic                touch_ab, touch_bc, touch_ca;
      r = '0;
      total = 0;
      touch_ab = 1'b0;
      touch_bc = 1'b0;
      touch_ca = 1'b0;
      unique case (w.command)
         CMD_CLEAR: mesh_size = 0;
         CMD_LOAD: begin
            if (mesh_size >= TAF_MAX_TRIANGLES) begin
               r.status = STATUS_FULL;
            end else begin
               corner_a[mesh_size] = w.vertex_a;
               corner_b[mesh_size] = w.vertex_b;
               corner_c[mesh_size] = w.vertex_c;
               r.triangle_number = NUMBER_W'(mesh_size);
               mesh_size++;
            end
         end
         CMD_QUERY: begin
            n = 32'(w.query_triangle);
            r.triangle_number = w.query_triangle;
            if (n >= mesh_size) begin
               r.status = STATUS_NOT_LOADED;
            end else begin
               mine[0] = corner_a[n];
               mine[1] = corner_b[n];
               mine[2] = corner_c[n];
               for (int i = 0; i < mesh_size; i++) begin
                  if (i != n) begin
                     theirs[0] = corner_a[i];
                     theirs[1] = corner_b[i];
                     theirs[2] = corner_c[i];
                     pairs = 0;
                     for (int x = 0; x < 3; x++)
                        for (int y = 0; y < 3; y++)
                           if (theirs[x] == mine[y]) pairs++;
                     if (pairs >= 2) begin
                        unique case (total)
                           0: r.neighbour_first = NUMBER_W'(i);
                           1: r.neighbour_second = NUMBER_W'(i);
                           2: r.neighbour_third = NUMBER_W'(i);
                           default: ;
                        endcase
                        total++;
                        if (edge_hits(theirs[0], theirs[1], theirs[2], mine[0], mine[1]) >= 2)
                           touch_ab = 1'b1;
                        if (edge_hits(theirs[0], theirs[1], theirs[2], mine[1], mine[2]) >= 2)
                           touch_bc = 1'b1;
                        if (edge_hits(theirs[0], theirs[1], theirs[2], mine[2], mine[0]) >= 2)
                           touch_ca = 1'b1;
                     end
                  end
               end
               r.neighbour_total = (total > NUMBER_MAX) ? NUMBER_MAX : NUMBER_W'(total);
               r.more_neighbours = (total > 3);
               r.edge_ab_open = !touch_ab;
               r.edge_bc_open = !touch_bc;
               r.edge_ca_open = !touch_ca;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         mesh_size = 0;
         awaited_answers.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_answers.size() == 0) begin
               $error("result word with no command waiting for it");
               fail_count++;
            end else begin
               want = awaited_answers.pop_front();
               compare_field("status", want.status, rsp_word.status);
               compare_field("triangle_number", want.triangle_number,
                             rsp_word.triangle_number);
               compare_field("neighbour_total", want.neighbour_total,
                             rsp_word.neighbour_total);
               compare_field("neighbour_first", want.neighbour_first,
                             rsp_word.neighbour_first);
               compare_field("neighbour_second", want.neighbour_second,
                             rsp_word.neighbour_second);
               compare_field("neighbour_third", want.neighbour_third,
                             rsp_word.neighbour_third);
               compare_field("more_neighbours", want.more_neighbours,
                             rsp_word.more_neighbours);
               compare_field("edge_ab_open", want.edge_ab_open, rsp_word.edge_ab_open);
               compare_field("edge_bc_open", want.edge_bc_open, rsp_word.edge_bc_open);
               compare_field("edge_ca_open", want.edge_ca_open, rsp_word.edge_ca_open);
            end
         end
         if (start && !busy)
            awaited_answers.insert(awaited_answers.size(), apply_command(req_word));
      end
      outstanding <= awaited_answers.size();
   end

endmodule

/* test/tb.sv */
// testbench top of the triangle adjacency finder: clock, reset, command words and verdict
`timescale 1ns / 1ps

module tb;
   import taf_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT  = 6000000;
   localparam int         RANDOM_ITEMS = 380;
   localparam int         DENSE_LOADS  = 150;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   logic         rsp_strobe;
   req_word_type req_word;
   rsp_word_type rsp_word;
   int           fail_count;
   int           outstanding;
   int           cycle_count = 0;
   bit           gaps_on;
   int           mesh_fill;

   triangle_adjacency_finder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   taf_neighbour_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [VERTEX_W-1:0] rand_vertex();
      return VERTEX_W'($urandom);
   endfunction

   function automatic logic [NUMBER_W-1:0] rand_number();
      return NUMBER_W'($urandom);
   endfunction

   function automatic logic [VERTEX_W-1:0] pool_vertex(input logic [VERTEX_W-1:0] base,
                                                       input int span);
      return base + VERTEX_W'($urandom_range(0, span));
   endfunction

   task automatic issue(input logic [1:0] cmd, input logic [VERTEX_W-1:0] a, b, c,
                        input logic [NUMBER_W-1:0] n);
      req_word_type w;
      w.command = cmd;
      w.vertex_a = a;
      w.vertex_b = b;
      w.vertex_c = c;
      w.query_triangle = n;
      if (gaps_on && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      unique case (cmd)
         CMD_CLEAR: mesh_fill = 0;
         CMD_LOAD: if (mesh_fill < TAF_MAX_TRIANGLES) mesh_fill++;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      int                  sent, steps, pick, span;
      logic [VERTEX_W-1:0] base;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      gaps_on = 1'b1;
      mesh_fill = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed words
      issue(CMD_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0);
      issue(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
      issue(CMD_LOAD, 16'd0, 16'd1, 16'd2, 10'h3FF);
      issue(CMD_LOAD, 16'd1, 16'd2, 16'd3, 10'd0);
      issue(CMD_LOAD, 16'd2, 16'd0, 16'hFFFF, 10'd0);
      issue(CMD_LOAD, 16'd0, 16'd1, 16'd7, 10'd0);
      issue(CMD_LOAD, 16'd9, 16'd9, 16'd9, 10'd0);
      issue(CMD_LOAD, 16'd9, 16'd9, 16'd8, 10'd0);
      issue(CMD_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0);
      issue(CMD_LOAD, 16'd8, 16'd10, 16'd11, 10'd0);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'd0);
      issue(CMD_LOAD, 16'd1, 16'd0, 16'd2, 10'd0);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'd0);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'd4);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'd5);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'd6);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'd7);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'd9);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'h3FF);
      issue(CMD_UNUSED, 16'd0, 16'd0, 16'd0, 10'd0);
      wait_drained();
      issue(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'd0);
      issue(CMD_LOAD, 16'hFFFF, 16'd0, 16'hFFFF, 10'd0);
      issue(CMD_QUERY, 16'd0, 16'd0, 16'd0, 10'd0);

      // random meshes from small vertex pools
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         issue(CMD_CLEAR, rand_vertex(), rand_vertex(), rand_vertex(), rand_number());
         sent++;
         base = rand_vertex();
         span = $urandom_range(2, 24);
         steps = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 140) : $urandom_range(2, 30);
         for (int k = 0; k < steps; k++) begin
            gaps_on = !(sent >= 200 && sent < 320);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               issue(CMD_LOAD, pool_vertex(base, span), pool_vertex(base, span),
                     pool_vertex(base, span), rand_number());
            end else if (pick < 82) begin
               if (mesh_fill > 0)
                  issue(CMD_QUERY, rand_vertex(), rand_vertex(), rand_vertex(),
                        NUMBER_W'($urandom_range(0, mesh_fill - 1)));
               else
                  issue(CMD_QUERY, rand_vertex(), rand_vertex(), rand_vertex(),
                        rand_number());
            end else if (pick < 88) begin
               issue(CMD_QUERY, rand_vertex(), rand_vertex(), rand_vertex(), rand_number());
            end else if (pick < 93) begin
               issue(CMD_LOAD, rand_vertex(), rand_vertex(), rand_vertex(), rand_number());
            end else if (pick < 97) begin
               issue(CMD_UNUSED, rand_vertex(), rand_vertex(), rand_vertex(), rand_number());
            end else begin
               issue(CMD_CLEAR, rand_vertex(), rand_vertex(), rand_vertex(), rand_number());
            end
            if (pick < 93 || pick >= 97) sent++;
            if ($urandom_range(0, 39) == 0) wait_drained();
         end
      end

      // dense pool so some queries see many neighbours
      gaps_on = 1'b1;
      issue(CMD_CLEAR, rand_vertex(), rand_vertex(), rand_vertex(), rand_number());
      base = rand_vertex();
      for (int k = 0; k < DENSE_LOADS; k++) begin
         span = (k < 100) ? 5 : 40;
         issue(CMD_LOAD, pool_vertex(base, span), pool_vertex(base, span),
               pool_vertex(base, span), rand_number());
      end
      issue(CMD_QUERY, rand_vertex(), rand_vertex(), rand_vertex(),
            NUMBER_W'(DENSE_LOADS - 1));
      issue(CMD_QUERY, rand_vertex(), rand_vertex(), rand_vertex(), 10'd0);
      repeat (4) issue(CMD_QUERY, rand_vertex(), rand_vertex(), rand_vertex(), rand_number());
      wait_drained();
      issue(CMD_CLEAR, rand_vertex(), rand_vertex(), rand_vertex(), rand_number());
      issue(CMD_QUERY, rand_vertex(), rand_vertex(), rand_vertex(), rand_number());

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/taf_pkg.sv
rtl/taf_ctrl.sv
rtl/taf_datapath.sv
rtl/triangle_adjacency_finder_unit.sv
test/taf_neighbour_checker.sv
test/tb.sv
